@@ rtl/tdpc_pkg.sv @@
// Shared types and constants for the two-dimensional parity frame corrector.
// Used by every module of the block; depends on nothing.
package tdpc_pkg;

  localparam int MaxRows  = 32;
  localparam int RowW     = 9;
  localparam int ByteW    = 8;
  localparam int AddrW    = $clog2(MaxRows);
  localparam int CountW   = $clog2(MaxRows + 1);
  localparam int ColW     = $clog2(RowW);
  localparam int BitSelW  = $clog2(ByteW);
  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  typedef enum logic [1:0] {
    STAT_CLEAN    = 2'd0,
    STAT_FIXED    = 2'd1,
    STAT_BAD      = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    S_COLLECT = 1'b0,
    S_DRAIN   = 1'b1
  } state_e;

  // Frame verdict, valid in the cycle the closing row is transferred.
  typedef struct packed {
    logic [CountW-1:0]  rows;
    status_e            status;
    logic               fix_en;
    logic [AddrW-1:0]   fix_idx;
    logic [BitSelW-1:0] fix_bit;
  } verdict_t;

  // Write request into the row store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } store_wr_t;

endpackage

@@ rtl/tdpc_row_mem.sv @@
// Row store of the parity frame corrector: one write port, one registered read port.
// Depends on tdpc_pkg.
module tdpc_row_mem
  import tdpc_pkg::*;
(
  input  logic             clk_i,
  input  store_wr_t        wr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem [MaxRows];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/tdpc_check.sv @@
// Row and column parity tracking for one frame and the verdict on the closing row.
// Depends on tdpc_pkg.
module tdpc_check
  import tdpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            accept_i,
  input  logic            closing_i,
  input  logic [RowW-1:0] row_i,
  output store_wr_t       wr_o,
  output verdict_t        verdict_o
);

  logic [RowW-1:0]   acc_q, acc_d;
  logic [1:0]        wcnt_q, wcnt_d;
  logic [CountW-1:0] widx_q, widx_d;
  logic [CountW-1:0] rows_q, rows_d;
  logic              ovf_q, ovf_d;

  logic              row_flag;
  logic              full;
  logic [RowW-1:0]   acc_n;
  logic [1:0]        wcnt_n;
  logic [CountW-1:0] widx_n;
  logic [RowW-1:0]   flagged;
  logic [ColW:0]     cols;
  logic [ColW-1:0]   pos;
  status_e           status;

  assign row_flag = ((^row_i) == mode_i);
  assign full     = (rows_q >= CountW'(MaxRows));

  // The row being transferred, folded into the running checks.
  always_comb begin
    acc_n  = acc_q ^ row_i;
    wcnt_n = wcnt_q;
    widx_n = widx_q;
    if (row_flag) begin
      if (wcnt_q != 2'd2) begin
        wcnt_n = wcnt_q + 2'd1;
      end
      widx_n = rows_q;
    end
  end

  always_comb begin
    flagged = acc_n ^ {RowW{~mode_i}};
    cols    = '0;
    pos     = '0;
    for (int b = 0; b < RowW; b++) begin
      if (flagged[b]) begin
        cols = cols + (ColW+1)'(1);
        pos  = ColW'(b);
      end
    end
    if (ovf_q) begin
      status = STAT_OVERFLOW;
    end else if (wcnt_n == 2'd0 && cols == '0) begin
      status = STAT_CLEAN;
    end else if (wcnt_n == 2'd1 && cols == (ColW+1)'(1)) begin
      status = STAT_FIXED;
    end else begin
      status = STAT_BAD;
    end
  end

  // A hit on the closing row or the parity column changes nothing that is sent.
  always_comb begin
    verdict_o.rows    = rows_q;
    verdict_o.status  = status;
    verdict_o.fix_en  = (status == STAT_FIXED) && (widx_n < rows_q) && (pos != '0);
    verdict_o.fix_idx = widx_n[AddrW-1:0];
    verdict_o.fix_bit = BitSelW'(pos - ColW'(1));
  end

  always_comb begin
    wr_o.en   = accept_i && !closing_i && !full;
    wr_o.addr = rows_q[AddrW-1:0];
    wr_o.data = row_i[RowW-1:1];
  end

  always_comb begin
    acc_d  = acc_q;
    wcnt_d = wcnt_q;
    widx_d = widx_q;
    rows_d = rows_q;
    ovf_d  = ovf_q;
    if (accept_i) begin
      if (closing_i) begin
        acc_d  = '0;
        wcnt_d = '0;
        widx_d = '0;
        rows_d = '0;
        ovf_d  = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        acc_d  = acc_n;
        wcnt_d = wcnt_n;
        widx_d = widx_n;
        rows_d = rows_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      wcnt_q <= '0;
      widx_q <= '0;
      rows_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      wcnt_q <= wcnt_d;
      widx_q <= widx_d;
      rows_q <= rows_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

@@ rtl/two_d_parity_frame_corrector_unit.sv @@
// Two-dimensional parity frame corrector. Data rows are taken one per cycle while
// s_axis_tready is high and written to a 32-entry row store while row and column parity
// are tracked; the closing parity row starts a drain that reads the store back, one
// registered memory read and then a load of the output register per byte, with the next
// read issued only after that load; output stalls slow the drain. A closing row with no
// data rows sends a single no-data word instead. Input is held off during the drain.
// A single flagged bit is corrected on the way out of the store.
// Depends on tdpc_pkg, tdpc_check and tdpc_row_mem.
module two_d_parity_frame_corrector_unit
  import tdpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,    // parity_mode
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [8:0] row_bits, rest zero
  input  logic                s_axis_tlast,   // is_parity_row
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, rest zero
  output logic                m_axis_tlast,   // last_byte
  output logic                m_axis_tuser    // no_data
);

  logic mode_q;

  state_e state_q, state_d;
  logic [CountW-1:0]  k_q, k_d;
  logic [CountW-1:0]  n_q, n_d;
  status_e            stat_q, stat_d;
  logic               fix_en_q, fix_en_d;
  logic [AddrW-1:0]   fix_idx_q, fix_idx_d;
  logic [BitSelW-1:0] fix_bit_q, fix_bit_d;
  logic               rd_pend_q;
  logic [AddrW-1:0]   rd_idx_q;

  logic               out_valid_q;
  logic [ByteW-1:0]   out_byte_q;
  status_e            out_stat_q;
  logic               out_last_q;
  logic               out_nodata_q;

  logic             out_free;
  logic             in_acc;
  logic             closing;
  logic             rd_en;
  logic [ByteW-1:0] rd_data;
  logic [ByteW-1:0] fixed_byte;
  store_wr_t        wr;
  verdict_t         verdict;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_COLLECT) && !rd_pend_q && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign closing       = in_acc && s_axis_tlast;
  assign rd_en         = (state_q == S_DRAIN) && !rd_pend_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  tdpc_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .accept_i  (in_acc),
    .closing_i (s_axis_tlast),
    .row_i     (s_axis_tdata[RowW-1:0]),
    .wr_o      (wr),
    .verdict_o (verdict)
  );

  tdpc_row_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (k_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    n_d       = n_q;
    stat_d    = stat_q;
    fix_en_d  = fix_en_q;
    fix_idx_d = fix_idx_q;
    fix_bit_d = fix_bit_q;
    case (state_q)
      S_COLLECT: begin
        if (closing && verdict.rows != '0) begin
          state_d   = S_DRAIN;
          k_d       = '0;
          n_d       = verdict.rows;
          stat_d    = verdict.status;
          fix_en_d  = verdict.fix_en;
          fix_idx_d = verdict.fix_idx;
          fix_bit_d = verdict.fix_bit;
        end
      end
      S_DRAIN: begin
        if (rd_en) begin
          k_d = k_q + CountW'(1);
          if (k_q == n_q - CountW'(1)) begin
            state_d = S_COLLECT;
          end
        end
      end
      default: state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    n_q       <= n_d;
    stat_q    <= stat_d;
    fix_en_q  <= fix_en_d;
    fix_idx_q <= fix_idx_d;
    fix_bit_q <= fix_bit_d;
    if (rd_en) begin
      rd_idx_q <= k_q[AddrW-1:0];
    end
  end

  always_comb begin
    fixed_byte = rd_data;
    if (fix_en_q && rd_idx_q == fix_idx_q) begin
      fixed_byte[fix_bit_q] = ~rd_data[fix_bit_q];
    end
  end

  // A pending read always finds the output register free: it was issued only
  // when the register was empty or being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_pend_q || (closing && verdict.rows == '0)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_byte_q   <= fixed_byte;
      out_stat_q   <= stat_q;
      out_last_q   <= ({1'b0, rd_idx_q} == n_q - CountW'(1));
      out_nodata_q <= 1'b0;
    end else if (closing && verdict.rows == '0) begin
      out_byte_q   <= '0;
      out_stat_q   <= verdict.status;
      out_last_q   <= 1'b1;
      out_nodata_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ByteW - 2)'(0), out_stat_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_nodata_q;

endmodule

@@ test/tb.sv @@
// Self-checking bench for two_d_parity_frame_corrector_unit: drives parity frames over the
// input stream, predicts every corrected byte in a frame checker class and compares on output.
// Depends on tdpc_pkg and the RTL of the block.
module tb;
  import tdpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 100;

  typedef struct packed {
    logic [ByteW-1:0] data;
    status_e          status;
    logic             last;
    logic             no_data;
  } out_byte_t;

  typedef enum int {
    FR_CLEAN,
    FR_DATA_FLIP,
    FR_CHECK_COL_FLIP,
    FR_CHECK_ROW_FLIP,
    FR_DOUBLE_FLIP,
    FR_NOISE
  } frame_kind_e;

  class frame_checker;
    logic [ByteW-1:0] store [MaxRows];
    logic [RowW-1:0]  col_acc;
    logic [1:0]       wrong_cnt;
    logic [5:0]       wrong_idx;
    logic [5:0]       rows;
    bit               ovf;
    bit               mode;
    out_byte_t        bytes_due[$];
    int               errors;
    int               frames;
    int               bytes_ok;
    int               status_count[4];

    function new();
      foreach (store[i]) store[i] = '0;
      mode   = 1'b1;
      errors = 0;
      frames = 0;
      bytes_ok = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col_acc   = '0;
      wrong_cnt = '0;
      wrong_idx = '0;
      rows      = '0;
      ovf       = 1'b0;
    endfunction

    function void set_mode(bit m);
      mode = m;
    endfunction

    function void tally_row(logic [RowW-1:0] row, logic [5:0] idx);
      col_acc = col_acc ^ row;
      if ((^row) == mode) begin
        if (wrong_cnt < 2) wrong_cnt++;
        wrong_idx = idx;
      end
    endfunction

    // Called for every accepted input transfer; a closing row queues the whole frame.
    function void note_row(logic [RowW-1:0] row, bit closing);
      status_e         st;
      logic [RowW-1:0] flagged;
      int              cols;
      int              pos;
      out_byte_t       item;
      if (!closing) begin
        if (rows >= MaxRows) begin
          ovf = 1'b1;
        end else begin
          store[rows[AddrW-1:0]] = row[8:1];
          tally_row(row, rows);
          rows++;
        end
        return;
      end
      tally_row(row, rows);
      if (ovf) begin
        st = STAT_OVERFLOW;
      end else begin
        flagged = col_acc ^ (mode ? 9'h000 : 9'h1FF);
        cols = 0;
        pos  = 0;
        for (int b = 0; b < RowW; b++) begin
          if (flagged[b]) begin
            cols++;
            pos = b;
          end
        end
        if (wrong_cnt == 0 && cols == 0) begin
          st = STAT_CLEAN;
        end else if (wrong_cnt == 1 && cols == 1) begin
          st = STAT_FIXED;
          // A hit on the closing row or the check column changes no stored bit.
          if (wrong_idx < rows && pos >= 1)
            store[wrong_idx[AddrW-1:0]] = store[wrong_idx[AddrW-1:0]] ^ (8'd1 << (pos - 1));
        end else begin
          st = STAT_BAD;
        end
      end
      status_count[st]++;
      frames++;
      if (rows == 0) begin
        item.data    = '0;
        item.status  = st;
        item.last    = 1'b1;
        item.no_data = 1'b1;
        bytes_due = {bytes_due, item};
      end else begin
        for (int k = 0; k < rows; k++) begin
          item.data    = store[k];
          item.status  = st;
          item.last    = (k == rows - 1);
          item.no_data = 1'b0;
          bytes_due = {bytes_due, item};
        end
      end
      clear_frame();
    endfunction

    function void check_byte(out_byte_t got);
      out_byte_t want;
      if (bytes_due.size() == 0) begin
        $error("unexpected output byte: data_byte %h status %0d", got.data, got.status);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (got.data !== want.data) begin
        $error("data_byte: expected %h, got %h", want.data, got.data);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_byte: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.no_data !== want.no_data) begin
        $error("no_data: expected %0b, got %0b", want.no_data, got.no_data);
        errors++;
      end
      bytes_ok++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_wdata;
  logic                s_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tlast;
  logic                m_axis_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  frame_checker sb;
  bit        cur_mode;
  int        burst_left;
  int        rows_in;
  int        idle_cycles;
  bit        hold_req;
  out_byte_t got_byte;

  always #5 clk_i = ~clk_i;

  two_d_parity_frame_corrector_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Transfer monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready) begin
        sb.note_row(s_tdata[RowW-1:0], s_tlast);
        rows_in++;
      end
      if (m_axis_tvalid && m_tready) begin
        got_byte.data    = m_axis_tdata[ByteW-1:0];
        got_byte.status  = status_e'(m_axis_tdata[ByteW+1:ByteW]);
        got_byte.last    = m_axis_tlast;
        got_byte.no_data = m_axis_tuser;
        sb.check_byte(got_byte);
      end
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $error("watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Output side: changes its stall pattern after each run of random length, or holds off on request.
  initial begin : receiver
    int pat_kind;
    int pat_left;
    int phase;
    m_tready = 1'b0;
    pat_kind = 0;
    pat_left = 0;
    phase    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 80);
        end
        pat_left--;
        phase++;
        case (pat_kind)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_row(input logic [RowW-1:0] row, input bit closing);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) burst_left = 120;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - RowW){1'b0}}, row};
    s_tlast  <= closing;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Pause the sender until every queued byte has come out.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (sb.bytes_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    wait_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_mode(m);
    cur_mode = m;
  endtask

  // Builds a frame that is well formed for the current mode (random rows for FR_NOISE), then damages it as asked.
  task automatic run_frame(input int n, input frame_kind_e kind);
    logic [RowW-1:0]  rows_q[$];
    logic [RowW-1:0]  acc;
    logic [ByteW-1:0] d;
    int r;
    int c;
    int r2;
    int c2;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      if (kind == FR_NOISE) begin
        rows_q = {rows_q, 9'($urandom)};
      end else begin
        d = 8'($urandom);
        rows_q = {rows_q, {d, (^d) ^ ~cur_mode}};
      end
      acc = acc ^ rows_q[i];
    end
    if (kind == FR_NOISE)
      rows_q = {rows_q, 9'($urandom)};
    else
      rows_q = {rows_q, (cur_mode ? acc : acc ^ 9'h1FF)};
    case (kind)
      FR_DATA_FLIP: begin
        if (n > 0) begin
          r = $urandom_range(0, n - 1);
          c = $urandom_range(1, 8);
          rows_q[r] = rows_q[r] ^ (9'd1 << c);
        end
      end
      FR_CHECK_COL_FLIP: begin
        if (n > 0) begin
          r = $urandom_range(0, n - 1);
          rows_q[r] = rows_q[r] ^ 9'd1;
        end
      end
      FR_CHECK_ROW_FLIP: begin
        c = $urandom_range(0, 8);
        rows_q[n] = rows_q[n] ^ (9'd1 << c);
      end
      FR_DOUBLE_FLIP: begin
        r = $urandom_range(0, n);
        c = $urandom_range(0, 8);
        do begin
          r2 = $urandom_range(0, n);
          c2 = $urandom_range(0, 8);
        end while (r2 == r && c2 == c);
        rows_q[r]  = rows_q[r] ^ (9'd1 << c);
        rows_q[r2] = rows_q[r2] ^ (9'd1 << c2);
      end
      default: ;
    endcase
    for (int i = 0; i <= n; i++) send_row(rows_q[i], i == n);
  endtask

  task automatic run_random_frame();
    int          sel;
    int          n;
    frame_kind_e kind;
    sel = $urandom_range(0, 99);
    if (sel < 5)       n = 0;
    else if (sel < 10) n = $urandom_range(MaxRows + 1, MaxRows + 4);
    else if (sel < 14) n = MaxRows;
    else if (sel < 24) n = $urandom_range(9, MaxRows - 1);
    else               n = $urandom_range(1, 8);
    sel = $urandom_range(0, 99);
    if (sel < 25)      kind = FR_CLEAN;
    else if (sel < 50) kind = FR_DATA_FLIP;
    else if (sel < 60) kind = FR_CHECK_COL_FLIP;
    else if (sel < 70) kind = FR_CHECK_ROW_FLIP;
    else if (sel < 85) kind = FR_DOUBLE_FLIP;
    else               kind = FR_NOISE;
    run_frame(n, kind);
    if ($urandom_range(0, 9) == 0) wait_results();
  endtask

  task automatic run_random_phase(input int target, input bit with_hold);
    int start;
    start = rows_in;
    // Always open a phase with a frame that overruns the store.
    run_frame(MaxRows + 1, FR_CLEAN);
    if (with_hold) begin
      // The receiver stalls while two frames are offered, so the drain backs up the input.
      hold_req = 1'b1;
      run_frame(6, FR_DATA_FLIP);
      run_frame(6, FR_CLEAN);
    end
    while (rows_in - start < target) run_random_frame();
  endtask

  initial begin : main
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    cur_mode    = 1'b1;
    burst_left  = 0;
    rows_in     = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed frames under the reset mode.
    run_frame(0, FR_CLEAN);
    send_row(9'h1FF, 1'b0);
    send_row(9'h000, 1'b0);
    send_row(9'h1FF, 1'b1);
    run_frame(3, FR_CLEAN);
    run_frame(3, FR_DATA_FLIP);
    run_frame(2, FR_CHECK_COL_FLIP);
    run_frame(2, FR_CHECK_ROW_FLIP);
    run_frame(2, FR_DOUBLE_FLIP);

    write_mode(1'b0);
    run_random_phase(150, 1'b1);
    write_mode(1'b1);
    run_random_phase(150, 1'b0);
    write_mode(1'b0);
    run_random_phase(150, 1'b0);

    wait_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (sb.bytes_due.size() != 0) begin
      $error("%0d expected bytes never came out", sb.bytes_due.size());
      sb.errors++;
    end
    $display("Ran %0d frames (%0d rows in, %0d bytes checked) under both parity modes.",
             sb.frames, rows_in, sb.bytes_ok);
    $display("Frame verdicts: clean %0d, corrected %0d, uncorrectable %0d, overflow %0d.",
             sb.status_count[STAT_CLEAN], sb.status_count[STAT_FIXED],
             sb.status_count[STAT_BAD], sb.status_count[STAT_OVERFLOW]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ two_d_parity_frame_corrector_unit.f @@
rtl/tdpc_pkg.sv
rtl/tdpc_row_mem.sv
rtl/tdpc_check.sv
rtl/two_d_parity_frame_corrector_unit.sv
test/tb.sv
